@@ hdl/uht_pkg.sv @@
// Shared types and constants for the unique-id handle table.
package uht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int DATA_BITS   = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int UID_W       = 32;
    localparam int LIMIT_W     = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
    localparam logic [UID_W-1:0]   UID_FIRST   = UID_W'(1);
    localparam logic [UID_W-1:0]   UID_LAST    = '1;

    typedef logic [1:0] t_op;
    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_GET = 2'd1;
    localparam t_op OP_REM = 2'd2;
    localparam t_op OP_NOP = 2'd3;

    typedef struct packed {
        t_op                  op;
        logic                 zero_uid;
        logic [UID_W-1:0]     uid;
        logic [DATA_BITS-1:0] data;
    } t_cmd;

endpackage

@@ hdl/uht_front.sv @@
// Front end: accepts items, classifies them and queues them for the engine.
module uht_front import uht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_lookup_uid,
    input  logic [63:0] i_entry_data_in,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_take
);

    // two-entry queue
    t_cmd        r_q [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_cnt, n_cnt;
    logic        w_push, w_take;
    t_cmd        w_cmd;

    always_comb begin
        w_cmd.op       = t_op'(i_mode);
        w_cmd.zero_uid = (i_lookup_uid == '0);
        w_cmd.uid      = i_lookup_uid;
        w_cmd.data     = i_entry_data_in[DATA_BITS-1:0];
    end

    assign full        = (r_cnt == 2'd2);
    assign w_push      = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_take      = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push;
        n_rd_ptr = r_rd_ptr ^ w_take;
        n_cnt    = r_cnt + 2'(w_push) - 2'(w_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

@@ hdl/uht_back.sv @@
// Back end: table storage, linear search engine, swap-remove and result register.
module uht_back import uht_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_take,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data,
    input  logic               pop,
    output logic               empty,
    output logic [31:0]        o_assigned_uid,
    output logic [63:0]        o_found_data,
    output logic               o_hit,
    output logic               o_rejected
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_MOVE_RD = 2'd2;
    localparam logic [1:0] S_MOVE_WR = 2'd3;

    logic [UID_W-1:0]     mem_id   [TABLE_DEPTH];
    logic [DATA_BITS-1:0] mem_word [TABLE_DEPTH];

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_live, n_live;
    logic [UID_W-1:0]     r_next_id, n_next_id;
    logic [LIMIT_W-1:0]   r_limit;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic                 r_pend, n_pend;
    logic [IDX_W-1:0]     r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic [DATA_BITS-1:0] r_found, n_found;
    t_cmd                 r_cmd, n_cmd;
    logic [UID_W-1:0]     r_rd_id;
    logic [DATA_BITS-1:0] r_rd_word;

    logic                 r_res_valid, n_res_valid;
    logic [31:0]          r_res_uid, n_res_uid;
    logic [63:0]          r_res_data, n_res_data;
    logic                 r_res_hit, n_res_hit;
    logic                 r_res_rej, n_res_rej;

    logic                 rd_en, wr_en;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic [UID_W-1:0]     wr_id;
    logic [DATA_BITS-1:0] wr_word;
    logic [CNT_W-1:0]     w_last;
    logic [31:0]          w_limit_eff;
    logic                 w_room;

    // limit above the depth acts as the depth
    assign w_limit_eff = (32'(r_limit) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : 32'(r_limit);
    assign w_room      = (32'(r_live) < w_limit_eff);
    assign w_last      = r_live - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_live      = r_live;
        n_next_id   = r_next_id;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_pos       = r_pos;
        n_found     = r_found;
        n_cmd       = r_cmd;
        o_cmd_take  = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_addr[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_live[IDX_W-1:0];
        wr_id       = r_next_id;
        wr_word     = i_cmd.data;
        n_res_valid = r_res_valid && !pop;
        n_res_uid   = r_res_uid;
        n_res_data  = r_res_data;
        n_res_hit   = r_res_hit;
        n_res_rej   = r_res_rej;

        unique case (r_state)
            S_IDLE: begin
                // one item in flight; start only with the result slot free
                if (i_cmd_valid && !r_res_valid) begin
                    o_cmd_take  = 1'b1;
                    n_cmd       = i_cmd;
                    n_res_uid   = '0;
                    n_res_data  = '0;
                    n_res_hit   = 1'b0;
                    n_res_rej   = 1'b0;
                    n_res_valid = 1'b1;
                    unique case (i_cmd.op)
                        OP_ADD: begin
                            if (w_room) begin
                                wr_en     = 1'b1;
                                n_live    = r_live + CNT_W'(1);
                                n_res_uid = r_next_id;
                                n_next_id = (r_next_id == UID_LAST) ? UID_FIRST
                                                                    : r_next_id + UID_W'(1);
                            end else begin
                                n_res_rej = 1'b1;
                            end
                        end
                        OP_GET, OP_REM: begin
                            if (!i_cmd.zero_uid && r_live != '0) begin
                                n_res_valid = 1'b0;
                                n_addr      = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // read issued one cycle, compared the next; stop at first match
                if (r_pend && r_rd_id == r_cmd.uid) begin
                    n_pos   = r_pend_idx;
                    n_found = r_rd_word;
                    if (r_cmd.op == OP_REM) begin
                        n_state = S_MOVE_RD;
                    end else begin
                        n_res_valid = 1'b1;
                        n_res_uid   = '0;
                        n_res_data  = 64'(r_rd_word);
                        n_res_hit   = 1'b1;
                        n_res_rej   = 1'b0;
                        n_state     = S_IDLE;
                    end
                end else if (r_addr < r_live) begin
                    rd_en      = 1'b1;
                    n_addr     = r_addr + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_addr[IDX_W-1:0];
                end else if (!r_pend) begin
                    n_res_valid = 1'b1;
                    n_res_uid   = '0;
                    n_res_data  = '0;
                    n_res_hit   = 1'b0;
                    n_res_rej   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            S_MOVE_RD: begin
                rd_en   = 1'b1;
                rd_addr = w_last[IDX_W-1:0];
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                // last entry fills the hole
                wr_en       = 1'b1;
                wr_addr     = r_pos;
                wr_id       = r_rd_id;
                wr_word     = r_rd_word;
                n_live      = w_last;
                n_res_valid = 1'b1;
                n_res_uid   = '0;
                n_res_data  = 64'(r_found);
                n_res_hit   = 1'b1;
                n_res_rej   = 1'b0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_next_id   <= UID_FIRST;
            r_limit     <= LIMIT_RESET;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_next_id   <= n_next_id;
            r_pend      <= n_pend;
            r_res_valid <= n_res_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_pend_idx <= n_pend_idx;
        r_pos      <= n_pos;
        r_found    <= n_found;
        r_cmd      <= n_cmd;
        r_res_uid  <= n_res_uid;
        r_res_data <= n_res_data;
        r_res_hit  <= n_res_hit;
        r_res_rej  <= n_res_rej;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_id[wr_addr]   <= wr_id;
            mem_word[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            r_rd_id   <= mem_id[rd_addr];
            r_rd_word <= mem_word[rd_addr];
        end
    end

    assign empty          = !r_res_valid;
    assign o_assigned_uid = r_res_uid;
    assign o_found_data   = r_res_data;
    assign o_hit          = r_res_hit;
    assign o_rejected     = r_res_rej;

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) <= 32'(TABLE_DEPTH))
        else $error("live count above table depth");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("next identifier is zero");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !r_res_valid)
        else $error("engine busy while a result is pending");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_cmd_take && i_cmd.op == OP_ADD && w_room)
        |=> r_live == $past(r_live) + CNT_W'(1))
        else $error("accepted add did not grow the table");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOVE_WR |=> r_live == $past(r_live) - CNT_W'(1) && r_res_hit)
        else $error("remove did not shrink the table");

endmodule

@@ hdl/unique_id_handle_table_core.sv @@
// Top level of the unique-id handle table: front queue plus search/update engine.
//
//  channel   handshake            payload
//  input     push / full          i_mode, i_lookup_uid, i_entry_data_in
//  result    empty / pop          o_assigned_uid, o_found_data, o_hit, o_rejected
//  config    i_cfg_we             i_cfg_data (table_limit)
//
// Add, no-op and lookups of id 0 or of an empty table complete from idle, with no table search.
// Get scans one entry per cycle through the single table read port; each read is
// registered, then compared, and a miss ends once the scan passes the end of the table.
// A remove that hits then reads the last entry and writes it into the hole.
// Reset is synchronous; the table needs no clearing pass after reset.
// Up to two items queue in front; the engine starts the next one only once its result is popped.
module unique_id_handle_table_core import uht_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_lookup_uid,
    input  logic [63:0] i_entry_data_in,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_assigned_uid,
    output logic [63:0] o_found_data,
    output logic        o_hit,
    output logic        o_rejected
);

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    uht_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_mode          (i_mode),
        .i_lookup_uid    (i_lookup_uid),
        .i_entry_data_in (i_entry_data_in),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_take      (cmd_take)
    );

    uht_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_cmd_take     (cmd_take),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .pop            (pop),
        .empty          (empty),
        .o_assigned_uid (o_assigned_uid),
        .o_found_data   (o_found_data),
        .o_hit          (o_hit),
        .o_rejected     (o_rejected)
    );

endmodule
